// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the pulse feature extractor
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pmtpfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pmtpfe_pkg
// Types and constants shared by the pulse feature extractor modules
// ----------------------------------------------------------------------------
package pmtpfe_pkg;

   localparam int SAMPLE_BITS_DEF = 14;
   localparam int CFG_W           = 14;
   localparam int IDX_W           = 14;
   localparam int SUM_W           = 24;
   localparam int RUN_W           = 23;
   localparam int CSR_IDX_W       = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_START  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_END    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_T0_THRESHOLD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOT_THRESHOLD = 3'd4;

   localparam logic [CFG_W-1:0] RST_BASELINE      = 14'd0;
   localparam logic [CFG_W-1:0] RST_WINDOW_START  = 14'd1900;
   localparam logic [CFG_W-1:0] RST_WINDOW_END    = 14'd2099;
   localparam logic [CFG_W-1:0] RST_T0_THRESHOLD  = 14'd10;
   localparam logic [CFG_W-1:0] RST_TOT_THRESHOLD = 14'd400;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_RUN  = 2'd1,
      PHASE_DONE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CFG_W-1:0] baseline;
      logic [CFG_W-1:0] window_start;
      logic [CFG_W-1:0] window_end;
      logic [CFG_W-1:0] t0_threshold;
      logic [CFG_W-1:0] tot_threshold;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0]        max_amplitude;
      logic signed [SUM_W-1:0] window_integral;
      logic [IDX_W-1:0]        t0_index;
      logic                    t0_found;
      logic [IDX_W-1:0]        tot_width;
      logic [RUN_W-1:0]        tot_integral;
      logic                    tot_found;
   } feat_type;

endpackage

// ----- rtl/pmtpfe_accum.sv -----
// ----------------------------------------------------------------------------
// pmtpfe_accum
// Per-waveform feature state: window max, integral, t0 and first TOT run
// ----------------------------------------------------------------------------
module pmtpfe_accum #(
   parameter int SAMPLE_BITS = pmtpfe_pkg::SAMPLE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                 first_sample,
   input  logic                 saturated,
   input  pmtpfe_pkg::cfg_type  cfg,
   output pmtpfe_pkg::feat_type feat
);
   import pmtpfe_pkg::*;

   localparam int SIG_W = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 1;

   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        max_ff, max_in, max_base;
   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_base;
   logic [IDX_W-1:0]        t0_idx_ff, t0_idx_in, t0_idx_base;
   logic                    t0_seen_ff, t0_seen_in, t0_seen_base;
   logic [IDX_W-1:0]        run_start_ff, run_start_in, run_start_base;
   logic [IDX_W-1:0]        run_end_ff, run_end_in, run_end_base;
   logic [RUN_W-1:0]        run_sum_ff, run_sum_in, run_sum_base;
   phase_type               phase_ff, phase_in, phase_base;
   logic                    sat_ff, sat_in;

   logic signed [SIG_W-1:0] sig;
   logic signed [SUM_W:0]   sum_wide;
   logic [RUN_W:0]          run_wide;
   logic                    in_win;
   logic                    above_tot;
   logic                    above_t0;
   logic                    above_max;
   logic                    run_track;
   logic                    tot_ok;

   // a first sample starts from cleared features
   assign idx_in         = first_sample ? '0 : idx_ff + 1'b1;
   assign sat_in         = first_sample ? saturated : sat_ff;
   assign max_base       = first_sample ? '0 : max_ff;
   assign sum_base       = first_sample ? '0 : sum_ff;
   assign t0_idx_base    = first_sample ? '0 : t0_idx_ff;
   assign t0_seen_base   = first_sample ? 1'b0 : t0_seen_ff;
   assign run_start_base = first_sample ? '0 : run_start_ff;
   assign run_end_base   = first_sample ? '0 : run_end_ff;
   assign run_sum_base   = first_sample ? '0 : run_sum_ff;
   assign phase_base     = first_sample ? PHASE_IDLE : phase_ff;

   // inverted, baseline-subtracted signal
   assign sig = $signed({{(SIG_W-CFG_W){1'b0}}, cfg.baseline})
              - $signed({{(SIG_W-SAMPLE_BITS){1'b0}}, sample});

   assign in_win    = (idx_in >= cfg.window_start) && (idx_in <= cfg.window_end);
   assign above_max = sig > $signed({{(SIG_W-IDX_W){1'b0}}, max_base});
   assign above_t0  = sig > $signed({{(SIG_W-CFG_W){1'b0}}, cfg.t0_threshold});
   assign above_tot = sig > $signed({{(SIG_W-CFG_W){1'b0}}, cfg.tot_threshold});
   assign run_track = in_win && !sat_in && (phase_base != PHASE_DONE);

   assign sum_wide = $signed({sum_base[SUM_W-1], sum_base})
                   + $signed({{(SUM_W+1-SIG_W){sig[SIG_W-1]}}, sig});
   // sig is positive wherever the run sum uses it
   assign run_wide = {1'b0, run_sum_base} + (RUN_W+1)'(sig[SIG_W-2:0]);

   always_comb begin
      max_in = max_base;
      sum_in = sum_base;
      t0_idx_in = t0_idx_base;
      t0_seen_in = t0_seen_base;
      if (in_win) begin
         if (above_max) begin
            max_in = sig[IDX_W-1:0];
         end
         // overflow shows as a mismatch of the two top bits
         if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
         end else begin
            sum_in = sum_wide[SUM_W-1:0];
         end
         if (!t0_seen_base && above_t0) begin
            t0_idx_in = idx_in;
            t0_seen_in = 1'b1;
         end
      end
   end

   // run phase: next state
   always_comb begin
      phase_in = phase_base;
      if (run_track) begin
         unique case (phase_base)
            PHASE_IDLE: if (above_tot) phase_in = PHASE_RUN;
            PHASE_RUN:  if (!above_tot) phase_in = PHASE_DONE;
            PHASE_DONE: phase_in = PHASE_DONE;
            default:    phase_in = phase_base;
         endcase
      end
   end

   // run phase: outputs
   always_comb begin
      run_start_in = run_start_base;
      run_end_in = run_end_base;
      run_sum_in = run_sum_base;
      if (run_track && above_tot) begin
         if (phase_base == PHASE_IDLE) begin
            run_start_in = idx_in;
         end
         run_end_in = idx_in;
         run_sum_in = run_wide[RUN_W] ? {RUN_W{1'b1}} : run_wide[RUN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         max_ff <= '0;
         sum_ff <= '0;
         t0_idx_ff <= '0;
         t0_seen_ff <= 1'b0;
         run_start_ff <= '0;
         run_end_ff <= '0;
         run_sum_ff <= '0;
         phase_ff <= PHASE_IDLE;
         sat_ff <= 1'b0;
      end else if (step) begin
         idx_ff <= idx_in;
         max_ff <= max_in;
         sum_ff <= sum_in;
         t0_idx_ff <= t0_idx_in;
         t0_seen_ff <= t0_seen_in;
         run_start_ff <= run_start_in;
         run_end_ff <= run_end_in;
         run_sum_ff <= run_sum_in;
         phase_ff <= phase_in;
         sat_ff <= sat_in;
      end
   end

   assign tot_ok = !sat_in && (phase_in != PHASE_IDLE);

   always_comb begin
      feat.max_amplitude = max_in;
      feat.window_integral = sum_in;
      feat.t0_index = t0_seen_in ? t0_idx_in : '0;
      feat.t0_found = t0_seen_in;
      feat.tot_width = tot_ok ? (run_end_in - run_start_in) : '0;
      feat.tot_integral = tot_ok ? run_sum_in : '0;
      feat.tot_found = tot_ok;
   end

endmodule

// ----- rtl/pmt_pulse_feature_extractor.sv -----
// ----------------------------------------------------------------------------
// pmt_pulse_feature_extractor
// Pulse features of a PMT waveform streamed one digitizer sample per transfer
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  req       req_valid/req_ready  sample, first_sample, last_sample, saturated
//  rsp       rsp_valid/rsp_ready  max_amplitude .. tot_found, one per waveform
//  csr       csr_valid/csr_ready  csr_index, csr_wdata (always ready)
//
//  One sample per cycle while no last sample waits on a stalled result. A sample
//  sits in the input register, where the feature update runs; the last sample's
//  features then go to the result register, which drives rsp_valid.
//  Synchronous reset clears features, index, valid flags and configuration to defaults.
//  A stalled result holds back a last sample waiting behind it, and new samples behind that.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmt_pulse_feature_extractor #(
   parameter int SAMPLE_BITS = pmtpfe_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [SAMPLE_BITS-1:0]           req_sample,
   input  logic                             req_first_sample,
   input  logic                             req_last_sample,
   input  logic                             req_saturated,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pmtpfe_pkg::IDX_W-1:0]     rsp_max_amplitude,
   output logic signed [pmtpfe_pkg::SUM_W-1:0] rsp_window_integral,
   output logic [pmtpfe_pkg::IDX_W-1:0]     rsp_t0_index,
   output logic                             rsp_t0_found,
   output logic [pmtpfe_pkg::IDX_W-1:0]     rsp_tot_width,
   output logic [pmtpfe_pkg::RUN_W-1:0]     rsp_tot_integral,
   output logic                             rsp_tot_found,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pmtpfe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pmtpfe_pkg::CFG_W-1:0]     csr_wdata
);
   import pmtpfe_pkg::*;

   cfg_type                cfg_ff;
   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] in_sample_ff;
   logic                   in_first_ff;
   logic                   in_last_ff;
   logic                   in_sat_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   feat_type               rsp_feat_ff;
   feat_type               feat;
   logic                   advance;
   logic                   req_xfer;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baseline <= RST_BASELINE;
         cfg_ff.window_start <= RST_WINDOW_START;
         cfg_ff.window_end <= RST_WINDOW_END;
         cfg_ff.t0_threshold <= RST_T0_THRESHOLD;
         cfg_ff.tot_threshold <= RST_TOT_THRESHOLD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BASELINE:      cfg_ff.baseline <= csr_wdata;
            CSR_WINDOW_START:  cfg_ff.window_start <= csr_wdata;
            CSR_WINDOW_END:    cfg_ff.window_end <= csr_wdata;
            CSR_T0_THRESHOLD:  cfg_ff.t0_threshold <= csr_wdata;
            CSR_TOT_THRESHOLD: cfg_ff.tot_threshold <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register; only a last sample waits on a full result register
   assign advance = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer = req_valid && req_ready;
   assign in_valid_in = req_xfer || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_sample_ff <= req_sample;
         in_first_ff <= req_first_sample;
         in_last_ff <= req_last_sample;
         in_sat_ff <= req_saturated;
      end
   end

   pmtpfe_accum #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_accum (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .sample(in_sample_ff),
      .first_sample(in_first_ff),
      .saturated(in_sat_ff),
      .cfg(cfg_ff),
      .feat(feat)
   );

   // result register
   always_comb begin
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_feat_ff <= feat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_max_amplitude = rsp_feat_ff.max_amplitude;
   assign rsp_window_integral = rsp_feat_ff.window_integral;
   assign rsp_t0_index = rsp_feat_ff.t0_index;
   assign rsp_t0_found = rsp_feat_ff.t0_found;
   assign rsp_tot_width = rsp_feat_ff.tot_width;
   assign rsp_tot_integral = rsp_feat_ff.tot_integral;
   assign rsp_tot_found = rsp_feat_ff.tot_found;

   `ASSERT_NEXT(a_last_gives_rsp, clock, reset, advance && in_last_ff, rsp_valid, "last sample produced no result")
   `ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !(advance && in_last_ff) && !(rsp_valid && !rsp_ready), !rsp_valid, "result without a last sample")
   `ASSERT_SAME(a_empty_input_ready, clock, reset, !in_valid_ff, req_ready, "empty input register not ready")
   `ASSERT_SAME(a_tot_nonzero, clock, reset, rsp_valid && rsp_tot_found, rsp_tot_integral != '0, "run found with zero integral")
   `ASSERT_SAME(a_t0_zero, clock, reset, rsp_valid && !rsp_t0_found, rsp_t0_index == '0, "t0 index set without crossing")

endmodule
